// ===== rtl/fplr_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point line rasterizer package
// Shared widths, result kind codes, default parameter values and the small
// rounding helpers used by the rasterizer.
// ----------------------------------------------------------------------------
package fplr_pkg;

    // Endpoint coordinates: unsigned, 6 fraction bits.
    localparam int COORD_W    = 12;
    localparam int COORD_FRAC = 6;
    // Half a pixel in endpoint units.
    localparam logic [COORD_W:0] HALF_PIX = (COORD_W + 1)'(32);
    // One pixel plus half a pixel, for span lengths.
    localparam logic [COORD_W:0] PIX_AND_HALF = (COORD_W + 1)'(96);

    // Result fields.
    localparam int KIND_W = 2;
    localparam int PIX_W  = 7;
    localparam int LEN_W  = 7;

    // Parameter defaults.
    localparam int TILE_PIXELS_DEF     = 64;
    localparam int SLOPE_FRAC_BITS_DEF = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PIXEL = 2'd0,
        KIND_HSPAN = 2'd1,
        KIND_VSPAN = 2'd2
    } t_kind;

    // Round a fixed-point coordinate to the nearest pixel, halves going up.
    function automatic logic [PIX_W-1:0] round_px(input logic [COORD_W-1:0] v);
        logic [COORD_W:0] s;
        s = {1'b0, v} + HALF_PIX;
        return s[COORD_W -: PIX_W];
    endfunction

    // Span length in pixels from the absolute endpoint distance.
    function automatic logic [LEN_W-1:0] span_len(input logic [COORD_W-1:0] d);
        logic [COORD_W:0] s;
        s = {1'b0, d} + PIX_AND_HALF;
        return s[COORD_W -: LEN_W];
    endfunction

endpackage

// ===== rtl/fixed_point_line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed-point line rasterizer
// Turns one line segment into a horizontal span, a vertical span or a run of
// single pixels stepped by a DDA, using one shared adder for the slope
// division, the start correction and the pixel stepping.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake                 Payload
// ---------  ---------  ------------------------  --------------------------------
// segment    in         start & !busy             i_begin_x/y, i_end_x/y,
//                                                 i_final_line
// result     out        o_valid, one cycle each   o_kind, o_pixel_x, o_pixel_y,
//                                                 o_span_length, o_last_of_line,
//                                                 o_last_of_batch
//
// A span item holds busy for one cycle after acceptance, and its one result is
// shown in the cycle in which busy has fallen. A sloped segment goes through
// classification, the divide, the start correction and a run of N pixels, where
// N is at most TILE_PIXELS. The last three use the one adder: a restoring divide
// producing one quotient bit per cycle, a shift-and-add start correction over
// the six fraction bits, and one DDA step per pixel.
// Reset is synchronous and active low; it returns the sequencer to idle and
// drops the result strobe. The receiver cannot stall, so results leave at one
// per cycle while a run is in progress.
//
module fixed_point_line_rasterizer_unit #(
    parameter int TILE_PIXELS     = fplr_pkg::TILE_PIXELS_DEF,
    parameter int SLOPE_FRAC_BITS = fplr_pkg::SLOPE_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        start,
    output logic                        busy,
    input  logic [fplr_pkg::COORD_W-1:0] i_begin_x,
    input  logic [fplr_pkg::COORD_W-1:0] i_begin_y,
    input  logic [fplr_pkg::COORD_W-1:0] i_end_x,
    input  logic [fplr_pkg::COORD_W-1:0] i_end_y,
    input  logic                        i_final_line,

    output logic                        o_valid,
    output logic [fplr_pkg::KIND_W-1:0] o_kind,
    output logic [fplr_pkg::PIX_W-1:0]  o_pixel_x,
    output logic [fplr_pkg::PIX_W-1:0]  o_pixel_y,
    output logic [fplr_pkg::LEN_W-1:0]  o_span_length,
    output logic                        o_last_of_line,
    output logic                        o_last_of_batch
);

    localparam int CW = fplr_pkg::COORD_W;
    localparam int PW = fplr_pkg::PIX_W;
    localparam int CF = fplr_pkg::COORD_FRAC;
    // Largest coordinate inside the tile, in endpoint units.
    localparam logic [CW-1:0] COORD_MAX = CW'(TILE_PIXELS * 64 - 1);
    // Quotient holds slopes up to and including one.
    localparam int QW = SLOPE_FRAC_BITS + 1;
    // Accumulator: the minor coordinate with SLOPE_FRAC_BITS + 6 fraction bits
    // and headroom for the sign and a step past the tile.
    localparam int AW = CW + SLOPE_FRAC_BITS + 4;
    localparam int CNT_W = $clog2(SLOPE_FRAC_BITS + 1);
    // Top bit of the emitted minor pixel inside the accumulator.
    localparam int PIX_MSB = SLOPE_FRAC_BITS + CF + PW - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DIVIDE,
        ST_CORRECT,
        ST_RUN
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_xb, r_yb, r_xe, r_ye;
    logic                 r_final;
    logic                 r_xmajor;
    logic                 r_neg;
    logic [CW-1:0]        r_dmaj;
    logic [CW-1:0]        r_rem;
    logic [QW-1:0]        r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic [CF-1:0]        r_frac;
    logic [AW-1:0]        r_acc;
    logic [PW-1:0]        r_pos;
    logic [PW-1:0]        r_end;

    logic                 r_valid;
    fplr_pkg::t_kind      r_kind;
    logic [PW-1:0]        r_px;
    logic [PW-1:0]        r_py;
    logic [fplr_pkg::LEN_W-1:0] r_len;
    logic                 r_last;
    logic                 r_lastb;

    // Input coordinates clamped to the tile.
    function automatic logic [CW-1:0] sat_coord(input logic [CW-1:0] v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // ------------------------------------------------------------------
    // Segment classification, evaluated in the cycle after acceptance.
    // ------------------------------------------------------------------
    logic [PW-1:0] c_ixb, c_iyb, c_ixe, c_iye;
    logic [CW-1:0] c_dx_abs, c_dy_abs;
    logic          c_xmajor, c_swap;
    logic [CW-1:0] c_bmaj, c_bmin, c_emin;
    logic [PW-1:0] c_pos, c_end;
    logic [CW:0]   c_bmin_half;
    logic [AW-1:0] c_acc_init;

    always_comb begin
        c_ixb = fplr_pkg::round_px(r_xb);
        c_iyb = fplr_pkg::round_px(r_yb);
        c_ixe = fplr_pkg::round_px(r_xe);
        c_iye = fplr_pkg::round_px(r_ye);
        c_dx_abs = (r_xb > r_xe) ? (r_xb - r_xe) : (r_xe - r_xb);
        c_dy_abs = (r_yb > r_ye) ? (r_yb - r_ye) : (r_ye - r_yb);
        c_xmajor = c_dx_abs > c_dy_abs;
        if (c_xmajor) begin
            // Walk along x from the smaller end.
            c_swap = r_xb > r_xe;
            c_bmaj = c_swap ? r_xe : r_xb;
            c_bmin = c_swap ? r_ye : r_yb;
            c_emin = c_swap ? r_yb : r_ye;
            c_pos  = c_swap ? c_ixe : c_ixb;
            c_end  = c_swap ? c_ixb : c_ixe;
        end else begin
            c_swap = r_yb > r_ye;
            c_bmaj = c_swap ? r_ye : r_yb;
            c_bmin = c_swap ? r_xe : r_xb;
            c_emin = c_swap ? r_xb : r_xe;
            c_pos  = c_swap ? c_iye : c_iyb;
            c_end  = c_swap ? c_iyb : c_iye;
        end
        // Starting the accumulator at (minor + half a pixel) scaled by the
        // slope precision folds the pixel-centre rounding into the DDA, so the
        // emitted pixel is a plain bit slice of the accumulator.
        c_bmin_half = {1'b0, c_bmin} + fplr_pkg::HALF_PIX;
        c_acc_init  = AW'(c_bmin_half) << SLOPE_FRAC_BITS;
    end

    // ------------------------------------------------------------------
    // The shared adder. The divide subtracts the major length from the
    // partial remainder; the start correction and the DDA add or subtract
    // the slope magnitude, shifted, to the accumulator.
    // ------------------------------------------------------------------
    logic [CW:0]   c_trial;
    logic [AW-1:0] c_op_a, c_op_b, c_sum;
    logic          c_sub;
    logic [2:0]    c_shift;
    logic          c_ge;

    always_comb begin
        c_trial = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        c_shift = (r_state == ST_RUN) ? 3'(CF) : r_cnt[2:0];
        if (r_state == ST_DIVIDE) begin
            c_op_a = AW'(c_trial);
            c_op_b = AW'(r_dmaj);
            c_sub  = 1'b1;
        end else begin
            c_op_a = r_acc;
            c_op_b = AW'(r_quo) << c_shift;
            c_sub  = r_neg;
        end
        c_sum = c_op_a + (c_sub ? ~c_op_b : c_op_b) + AW'(c_sub);
        c_ge  = ~c_sum[AW-1];
    end

    logic [PW-1:0] c_pix_minor;
    logic [PW-1:0] c_pos_next;
    logic          c_run_last;

    assign c_pix_minor = r_acc[PIX_MSB -: PW];
    assign c_pos_next  = r_pos + PW'(1);
    assign c_run_last  = (c_pos_next == r_end);

    // ------------------------------------------------------------------
    // Sequencer and registered results.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_xb    <= sat_coord(i_begin_x);
                        r_yb    <= sat_coord(i_begin_y);
                        r_xe    <= sat_coord(i_end_x);
                        r_ye    <= sat_coord(i_end_y);
                        r_final <= i_final_line;
                        r_state <= ST_CLASSIFY;
                    end
                end
                ST_CLASSIFY: begin
                    if (c_iyb == c_iye) begin
                        // Same row: one horizontal span from the left end.
                        r_valid <= 1'b1;
                        r_kind  <= fplr_pkg::KIND_HSPAN;
                        r_px    <= fplr_pkg::round_px((r_xb < r_xe) ? r_xb : r_xe);
                        r_py    <= c_iyb;
                        r_len   <= fplr_pkg::span_len(c_dx_abs);
                        r_last  <= 1'b1;
                        r_lastb <= r_final;
                        r_state <= ST_IDLE;
                    end else if (c_ixb == c_ixe) begin
                        // Same column: one vertical span from the top end.
                        r_valid <= 1'b1;
                        r_kind  <= fplr_pkg::KIND_VSPAN;
                        r_px    <= c_ixb;
                        r_py    <= fplr_pkg::round_px((r_yb < r_ye) ? r_yb : r_ye);
                        r_len   <= fplr_pkg::span_len(c_dy_abs);
                        r_last  <= 1'b1;
                        r_lastb <= r_final;
                        r_state <= ST_IDLE;
                    end else begin
                        r_xmajor <= c_xmajor;
                        r_neg    <= c_emin < c_bmin;
                        r_dmaj   <= c_xmajor ? c_dx_abs : c_dy_abs;
                        r_rem    <= c_xmajor ? c_dy_abs : c_dx_abs;
                        r_quo    <= '0;
                        r_cnt    <= '0;
                        r_frac   <= CF'(6'd32 - c_bmaj[CF-1:0]);
                        r_acc    <= c_acc_init;
                        r_pos    <= c_pos;
                        r_end    <= c_end;
                        r_state  <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    // Restoring divide of minor length, scaled by the slope
                    // precision, by major length: one quotient bit a cycle,
                    // the first without a shift since the minor never exceeds
                    // the major.
                    r_rem <= c_ge ? c_sum[CW-1:0] : c_trial[CW-1:0];
                    r_quo <= {r_quo[QW-2:0], c_ge};
                    if (r_cnt == CNT_W'(SLOPE_FRAC_BITS)) begin
                        r_cnt   <= '0;
                        r_state <= ST_CORRECT;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_CORRECT: begin
                    // Multiply the slope by the distance to the first pixel
                    // centre, one fraction bit a cycle.
                    if (r_frac[r_cnt[2:0]]) begin
                        r_acc <= c_sum;
                    end
                    if (r_cnt == CNT_W'(CF - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_RUN;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_RUN: begin
                    // One pixel per major step; the end pixel is excluded.
                    r_valid <= 1'b1;
                    r_kind  <= fplr_pkg::KIND_PIXEL;
                    r_px    <= r_xmajor ? r_pos : c_pix_minor;
                    r_py    <= r_xmajor ? c_pix_minor : r_pos;
                    r_len   <= fplr_pkg::LEN_W'(1);
                    r_last  <= c_run_last;
                    r_lastb <= c_run_last & r_final;
                    r_acc   <= c_sum;
                    r_pos   <= c_pos_next;
                    if (c_run_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_span_length   = r_len;
    assign o_last_of_line  = r_last;
    assign o_last_of_batch = r_lastb;

endmodule

// ===== tb/tb_fixed_point_line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench for the fixed-point line rasterizer
// Feeds line segments through the start/busy command port, first from a
// directed table and then at random, and checks every span or pixel that the
// block emits against a typed-in expectation or an in-bench rasterizer, field by field and in order.
// ----------------------------------------------------------------------------
module tb_fixed_point_line_rasterizer_unit;

    localparam int TILE       = fplr_pkg::TILE_PIXELS_DEF;
    localparam int SLOPE_FRAC = fplr_pkg::SLOPE_FRAC_BITS_DEF;
    localparam int COORD_TOP  = TILE * 64 - 1;
    // Number of random segments after the directed table.
    localparam int RANDOM_SEGMENTS = 100;
    // Allow a generous margin after the last expected pixel so that any stray
    // result still shows up.
    localparam int DRAIN_CYCLES = 100;
    // Longest legal stretch without any accepted item or result is the
    // sender's gap plus the divide and start correction, well under this.
    localparam int IDLE_LIMIT = 2000;

    // One input item: a segment with its batch flag.
    typedef struct {
        logic [fplr_pkg::COORD_W-1:0] bx;
        logic [fplr_pkg::COORD_W-1:0] by;
        logic [fplr_pkg::COORD_W-1:0] ex;
        logic [fplr_pkg::COORD_W-1:0] ey;
        logic                         fin;
    } t_segment;

    // One result: a span or a single pixel.
    typedef struct {
        fplr_pkg::t_kind              kind;
        logic [fplr_pkg::PIX_W-1:0]   x;
        logic [fplr_pkg::PIX_W-1:0]   y;
        logic [fplr_pkg::LEN_W-1:0]   len;
        logic                         lol;
        logic                         lob;
    } t_fragment;

    // A row of the directed table. Rows whose outcome is obvious carry a
    // typed-in expectation; the rest go through the rasterizer below.
    typedef struct {
        t_segment  seg;
        bit        typed;
        t_fragment want;
    } t_table_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [fplr_pkg::COORD_W-1:0] i_begin_x = '0;
    logic [fplr_pkg::COORD_W-1:0] i_begin_y = '0;
    logic [fplr_pkg::COORD_W-1:0] i_end_x = '0;
    logic [fplr_pkg::COORD_W-1:0] i_end_y = '0;
    logic                         i_final_line = 1'b0;
    logic                         o_valid;
    logic [fplr_pkg::KIND_W-1:0]  o_kind;
    logic [fplr_pkg::PIX_W-1:0]   o_pixel_x;
    logic [fplr_pkg::PIX_W-1:0]   o_pixel_y;
    logic [fplr_pkg::LEN_W-1:0]   o_span_length;
    logic                         o_last_of_line;
    logic                         o_last_of_batch;

    // Fragments the block still owes us, oldest first.
    t_fragment  fragment_q[$];
    t_table_row directed_q[$];

    int mismatches = 0;
    int segments_sent = 0;
    int spans_seen = 0;
    int pixels_seen = 0;
    int idle_cycles = 0;

    fixed_point_line_rasterizer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_begin_x       (i_begin_x),
        .i_begin_y       (i_begin_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_final_line    (i_final_line),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_span_length   (o_span_length),
        .o_last_of_line  (o_last_of_line),
        .o_last_of_batch (o_last_of_batch)
    );

    // Period of 4: two units high, two low.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Rasterizer used for prediction
    // ------------------------------------------------------------------------

    // Coordinates beyond the tile saturate to its last sub-pixel position.
    function automatic longint clamp_coord(input logic [fplr_pkg::COORD_W-1:0] v);
        longint c;
        c = longint'(v);
        return (c > COORD_TOP) ? longint'(COORD_TOP) : c;
    endfunction

    // Nearest pixel, halves rounding up; the shift is a floor shift.
    function automatic longint px_round(input longint v);
        return (v + 32) >>> fplr_pkg::COORD_FRAC;
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_fragment make_fragment(input fplr_pkg::t_kind k,
                                                input longint x, input longint y,
                                                input longint len,
                                                input bit lol, input bit fin);
        t_fragment f;
        f.kind = k;
        f.x    = x[fplr_pkg::PIX_W-1:0];
        f.y    = y[fplr_pkg::PIX_W-1:0];
        f.len  = len[fplr_pkg::LEN_W-1:0];
        f.lol  = lol;
        f.lob  = lol & fin;
        return f;
    endfunction

    // Works out every fragment of one segment and queues them in order.
    function automatic void rasterize_segment(input t_segment s);
        longint xb, yb, xe, ye;
        longint ixb, iyb, ixe, iye;
        longint dx, dy, slope, minor, pos, stop, t, m;
        bit     xmajor, last;
        int     n;
        xb  = clamp_coord(s.bx);
        yb  = clamp_coord(s.by);
        xe  = clamp_coord(s.ex);
        ye  = clamp_coord(s.ey);
        ixb = px_round(xb);
        iyb = px_round(yb);
        ixe = px_round(xe);
        iye = px_round(ye);
        n   = 0;

        // Same row after rounding: one horizontal span from the left end.
        if (iyb == iye) begin
            fragment_q.push_back(make_fragment(fplr_pkg::KIND_HSPAN,
                                 px_round((xb < xe) ? xb : xe),
                                 iyb, px_round(mag(xe - xb) + 64), 1'b1, s.fin));
            return;
        end
        // Same column after rounding: one vertical span from the top end.
        if (ixb == ixe) begin
            fragment_q.push_back(make_fragment(fplr_pkg::KIND_VSPAN, ixb,
                                 px_round((yb < ye) ? yb : ye),
                                 px_round(mag(ye - yb) + 64), 1'b1, s.fin));
            return;
        end

        // The slope comes from the differences taken before the endpoints
        // are put in order; the ratio is the same either way.
        dx     = xe - xb;
        dy     = ye - yb;
        xmajor = mag(dx) > mag(dy);
        if (xmajor) begin
            if (xb > xe) begin
                t = xb;  xb = xe;   xe = t;
                t = yb;  yb = ye;   ye = t;
                t = ixb; ixb = ixe; ixe = t;
            end
            slope = (dy * (longint'(1) << SLOPE_FRAC)) / dx;
            minor = yb * (longint'(1) << (SLOPE_FRAC - fplr_pkg::COORD_FRAC))
                  + ((slope * ((32 - xb) & 63)) >>> fplr_pkg::COORD_FRAC);
            pos   = ixb;
            stop  = ixe;
        end else begin
            if (yb > ye) begin
                t = xb;  xb = xe;   xe = t;
                t = yb;  yb = ye;   ye = t;
                t = iyb; iyb = iye; iye = t;
            end
            slope = (dx * (longint'(1) << SLOPE_FRAC)) / dy;
            minor = xb * (longint'(1) << (SLOPE_FRAC - fplr_pkg::COORD_FRAC))
                  + ((slope * ((32 - yb) & 63)) >>> fplr_pkg::COORD_FRAC);
            pos   = iyb;
            stop  = iye;
        end

        // DDA: one pixel per major step, the end pixel itself excluded.
        while (pos < stop && n < TILE) begin
            m    = (minor + (longint'(1) << (SLOPE_FRAC - 1))) >>> SLOPE_FRAC;
            last = (pos + 1 >= stop) || (n + 1 >= TILE);
            if (xmajor) begin
                fragment_q.push_back(make_fragment(fplr_pkg::KIND_PIXEL, pos, m, 1,
                                                   last, s.fin));
            end else begin
                fragment_q.push_back(make_fragment(fplr_pkg::KIND_PIXEL, m, pos, 1,
                                                   last, s.fin));
            end
            n++;
            minor += slope;
            pos++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_table_row line_row(input int bx, input int by, input int ex,
                                            input int ey, input bit fin);
        t_table_row r;
        r.seg.bx  = bx[fplr_pkg::COORD_W-1:0];
        r.seg.by  = by[fplr_pkg::COORD_W-1:0];
        r.seg.ex  = ex[fplr_pkg::COORD_W-1:0];
        r.seg.ey  = ey[fplr_pkg::COORD_W-1:0];
        r.seg.fin = fin;
        r.typed   = 1'b0;
        r.want    = make_fragment(fplr_pkg::KIND_PIXEL, 0, 0, 0, 1'b0, 1'b0);
        return r;
    endfunction

    // A span row whose single result is typed in directly.
    function automatic t_table_row span_row(input int bx, input int by, input int ex,
                                            input int ey, input bit fin,
                                            input fplr_pkg::t_kind k,
                                            input int x, input int y, input int len);
        t_table_row r;
        r       = line_row(bx, by, ex, ey, fin);
        r.typed = 1'b1;
        r.want  = make_fragment(k, x, y, len, 1'b1, fin);
        return r;
    endfunction

    function automatic int clip_coord(input int v);
        if (v < 0) begin
            return 0;
        end
        return (v > 4095) ? 4095 : v;
    endfunction

    // Random segment: a mix of spans, short sloped lines and anything at all.
    function automatic t_table_row random_row();
        int          bx, by, ex, ey;
        int unsigned sel;
        bit          fin;
        sel = $urandom_range(0, 9);
        bx  = $urandom_range(0, 4095);
        by  = $urandom_range(0, 4095);
        ex  = $urandom_range(0, 4095);
        ey  = $urandom_range(0, 4095);
        fin = ($urandom_range(0, 3) == 0);
        case (sel) inside
            [0:1]: begin
                // Horizontal, sometimes only within the same rounded row.
                ey = clip_coord(by + $urandom_range(0, 1) * ($urandom_range(0, 40) - 20));
            end
            [2:3]: begin
                ex = clip_coord(bx + $urandom_range(0, 1) * ($urandom_range(0, 40) - 20));
            end
            [4:5]: begin
                // Short line of a few pixels in any direction.
                ex = clip_coord(bx + int'($urandom_range(0, 1280)) - 640);
                ey = clip_coord(by + int'($urandom_range(0, 1280)) - 640);
            end
            default: begin
            end
        endcase
        return line_row(bx, by, ex, ey, fin);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Presents one segment after a gap and holds it until the block takes it.
    // The gap starts at the edge that accepted the previous segment, so start
    // rises at any point of the block's work. With no gap, start simply stays
    // high and only the payload changes.
    task automatic issue_segment(input t_table_row r, input int unsigned gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_begin_x    <= r.seg.bx;
        i_begin_y    <= r.seg.by;
        i_end_x      <= r.seg.ex;
        i_end_y      <= r.seg.ey;
        i_final_line <= r.seg.fin;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        if (r.typed) begin
            fragment_q.push_back(r.want);
        end else begin
            rasterize_segment(r.seg);
        end
        segments_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every strobe is matched against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fragment w;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (fragment_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d x=%0d y=%0d len=%0d",
                                          o_kind, o_pixel_x, o_pixel_y, o_span_length));
            end else begin
                w = fragment_q.pop_front();
                if (o_kind !== w.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", o_kind, w.kind));
                if (o_pixel_x !== w.x)
                    report_mismatch($sformatf("pixel_x %0d, expected %0d", o_pixel_x, w.x));
                if (o_pixel_y !== w.y)
                    report_mismatch($sformatf("pixel_y %0d, expected %0d", o_pixel_y, w.y));
                if (o_span_length !== w.len)
                    report_mismatch($sformatf("span_length %0d, expected %0d",
                                              o_span_length, w.len));
                if (o_last_of_line !== w.lol)
                    report_mismatch($sformatf("last_of_line %0b, expected %0b",
                                              o_last_of_line, w.lol));
                if (o_last_of_batch !== w.lob)
                    report_mismatch($sformatf("last_of_batch %0b, expected %0b",
                                              o_last_of_batch, w.lob));
                if (w.kind == fplr_pkg::KIND_PIXEL) begin
                    pixels_seen++;
                end else begin
                    spans_seen++;
                end
            end
        end
    end

    // Watchdog: any accepted segment or result restarts the count.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || (i_rst_n === 1'b1 && o_valid === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     fragment_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int          burst_left;
        int unsigned gap;

        // Extremes of every field, both spans in both directions, rounding
        // edges at half a pixel, spans that exist only after rounding, the
        // longest diagonal and sloped lines: all y-major octants, one x-major octant.
        directed_q.push_back(span_row(0, 0, 0, 0, 1'b0, fplr_pkg::KIND_HSPAN, 0, 0, 1));
        directed_q.push_back(span_row(4095, 4095, 4095, 4095, 1'b1, fplr_pkg::KIND_HSPAN,
                                      64, 64, 1));
        directed_q.push_back(span_row(0, 0, 4095, 0, 1'b1, fplr_pkg::KIND_HSPAN, 0, 0, 65));
        directed_q.push_back(span_row(4095, 0, 0, 0, 1'b0, fplr_pkg::KIND_HSPAN, 0, 0, 65));
        directed_q.push_back(span_row(0, 0, 0, 4095, 1'b0, fplr_pkg::KIND_VSPAN, 0, 0, 65));
        directed_q.push_back(span_row(0, 4095, 0, 0, 1'b1, fplr_pkg::KIND_VSPAN, 0, 0, 65));
        // Just below and at half a pixel: the ends land in columns zero and
        // one, and the span starts at column zero.
        directed_q.push_back(span_row(31, 0, 32, 0, 1'b0, fplr_pkg::KIND_HSPAN, 0, 0, 1));
        // The y values differ but round to the same row.
        directed_q.push_back(span_row(0, 31, 4095, 0, 1'b0, fplr_pkg::KIND_HSPAN, 0, 0, 65));
        // The x values differ but round to the same column.
        directed_q.push_back(span_row(40, 0, 90, 4095, 1'b1, fplr_pkg::KIND_VSPAN, 1, 0, 65));
        directed_q.push_back(span_row(100, 2000, 3000, 2010, 1'b0, fplr_pkg::KIND_HSPAN,
                                      2, 31, 46));
        // Sloped lines: equal deltas go y-major; both orders of the endpoints.
        directed_q.push_back(line_row(0, 0, 4095, 4095, 1'b1));
        directed_q.push_back(line_row(4095, 4095, 0, 0, 1'b0));
        directed_q.push_back(line_row(0, 0, 4095, 2048, 1'b0));
        directed_q.push_back(line_row(0, 4095, 4095, 0, 1'b1));
        directed_q.push_back(line_row(4095, 0, 0, 4095, 1'b0));
        directed_q.push_back(line_row(100, 0, 900, 4095, 1'b0));
        directed_q.push_back(line_row(900, 4095, 100, 0, 1'b1));
        // One-pixel sloped line, and lines with fractional start points.
        directed_q.push_back(line_row(0, 0, 64, 64, 1'b0));
        directed_q.push_back(line_row(10, 50, 3000, 1000, 1'b0));
        directed_q.push_back(line_row(4095, 10, 4000, 4095, 1'b1));
        // Alternating bit patterns on every coordinate.
        directed_q.push_back(line_row(12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b0));
        directed_q.push_back(line_row(12'h555, 12'hAAA, 12'hAAA, 12'h555, 1'b1));

        // Synchronous reset held from the start, then released at an edge.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[i]) begin
            issue_segment(directed_q[i], $urandom_range(0, 15));
        end

        // Random part: mostly random gaps, with occasional bursts in which
        // segments follow each other with start held high throughout.
        burst_left = 0;
        for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
            if (burst_left == 0 && $urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(4, 12);
            end
            if (burst_left > 0) begin
                gap = 0;
                burst_left--;
            end else begin
                gap = $urandom_range(0, 15);
            end
            issue_segment(random_row(), gap);
        end
        start <= 1'b0;

        // Wait for the last fragment, then a little longer for strays.
        while (fragment_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Rasterized %0d segments (%0d from the table, %0d random).",
                 segments_sent, directed_q.size(), RANDOM_SEGMENTS);
        $display("Checked %0d spans and %0d single pixels, %0d mismatches.",
                 spans_seen, pixels_seen, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
